[design/mmp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the Markov miss prefetcher.
// No dependencies.
package mmp_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int SUCCESSORS_DEF    = 5;
    localparam int ADDR_WIDTH_DEF    = 48;

    localparam int            LINE_BYTES_W     = 13;
    localparam logic [12:0]   LINE_BYTES_RESET = 13'd64;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_SHIFT = 2'd1;
    localparam logic [1:0] CELL_LOAD  = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       cmp_en;
    } cell_ctl_t;

endpackage

[design/mmp_cell.sv]
`timescale 1ns / 1ps
// One table entry: tag, successor list and count, with tag compare.
// Depends on mmp_pkg.
module mmp_cell import mmp_pkg::*; #(
    parameter int SUCCESSORS = SUCCESSORS_DEF,
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
    localparam int CW = $clog2(SUCCESSORS + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cell_ctl_t                    ctl,
    input  logic [ADDR_WIDTH-1:0]        cmp_addr,
    input  logic                         sh_valid,
    input  logic [ADDR_WIDTH-1:0]        sh_tag,
    input  logic [CW-1:0]                sh_cnt,
    input  logic [SUCCESSORS*ADDR_WIDTH-1:0] sh_succ,
    input  logic                         ld_valid,
    input  logic [ADDR_WIDTH-1:0]        ld_tag,
    input  logic [CW-1:0]                ld_cnt,
    input  logic [SUCCESSORS*ADDR_WIDTH-1:0] ld_succ,
    output logic                         valid,
    output logic [ADDR_WIDTH-1:0]        tag,
    output logic [CW-1:0]                cnt,
    output logic [SUCCESSORS*ADDR_WIDTH-1:0] succ,
    output logic                         match
);

    logic                             valid_reg;
    logic [CW-1:0]                    cnt_reg;
    logic [ADDR_WIDTH-1:0]            tag_reg;
    logic [SUCCESSORS*ADDR_WIDTH-1:0] succ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            unique case (ctl.op)
                CELL_SHIFT: begin
                    valid_reg <= sh_valid;
                    cnt_reg   <= sh_cnt;
                end
                CELL_LOAD: begin
                    valid_reg <= ld_valid;
                    cnt_reg   <= ld_cnt;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (ctl.op)
            CELL_SHIFT: begin
                tag_reg  <= sh_tag;
                succ_reg <= sh_succ;
            end
            CELL_LOAD: begin
                tag_reg  <= ld_tag;
                succ_reg <= ld_succ;
            end
            default: ;
        endcase
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign cnt   = cnt_reg;
    assign succ  = succ_reg;
    assign match = ctl.cmp_en && valid_reg && (tag_reg == cmp_addr);

endmodule

[design/markov_miss_prefetcher.sv]
`timescale 1ns / 1ps
// Markov miss-correlation prefetcher top level: control, list update, output.
// Depends on mmp_pkg and mmp_cell.
//
// Usage:
//   s_ channel: one access per transaction, address in s_tdata, miss flag
//   in s_tuser. m_ channel: the successors of the matching table entry,
//   most recent first, m_tlast on the final one. An access with no
//   matching entry yields nothing.
//   A miss or the seed access steps through tag compare, table update,
//   lookup compare and select before its first result; a hit steps
//   through lookup compare and select only. Results then follow one per
//   cycle while m_tready is high. A new access is taken only after the
//   current one has finished, its last result included.
//   s_tready is high only while the sequencer is idle.
//   Reset: table empty, previous miss zero, line size 64. The first
//   access after reset seeds the table with address -> address+line size.
//   A stalled m_ channel holds the current result and the sequencer waits.
//   Write the line size via cfg_we/cfg_wdata only while idle; not enforced.
module markov_miss_prefetcher import mmp_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int SUCCESSORS    = SUCCESSORS_DEF,
    parameter int ADDR_WIDTH    = ADDR_WIDTH_DEF,
    localparam int DW = ((ADDR_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [LINE_BYTES_W-1:0] cfg_wdata,    // line size in bytes
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [DW-1:0]           s_tdata,      // access address
    input  logic                    s_tuser,      // miss
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DW-1:0]           m_tdata,      // prefetch_addr
    output logic                    m_tlast       // last
);

    localparam int CW = $clog2(SUCCESSORS + 1);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = SUCCESSORS * ADDR_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MATCH = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_LOOK  = 3'd3;
    localparam logic [2:0] ST_SEL   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [LINE_BYTES_W-1:0]   bsize_reg;
    logic [ADDR_WIDTH-1:0]     addr_reg, prev_reg, from_reg, to_reg;
    logic [TABLE_ENTRIES-1:0]  hitv_reg;
    logic [LW-1:0]             ob_reg;
    logic [CW-1:0]             rem_reg;

    logic [TABLE_ENTRIES-1:0]  vld, mt;
    logic [ADDR_WIDTH-1:0]     tg [TABLE_ENTRIES];
    logic [CW-1:0]             ct [TABLE_ENTRIES];
    logic [LW-1:0]             sc [TABLE_ENTRIES];
    cell_ctl_t                 ctl [TABLE_ENTRIES];
    logic [ADDR_WIDTH-1:0]     cmp_addr;

    logic [ADDR_WIDTH-1:0]     in_addr;
    logic                      s_acc, m_acc, seed;

    logic [CW-1:0]             sel_cnt;
    logic [LW-1:0]             sel_succ;
    logic [IW-1:0]             hit_idx;
    logic                      any_hit;
    logic [LW-1:0]             upd_succ;
    logic [CW-1:0]             upd_cnt;
    logic                      found;
    logic [CW-1:0]             found_j;

    assign in_addr = s_tdata[ADDR_WIDTH-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;
    assign seed = !vld[0];
    assign cmp_addr = (state_reg == ST_MATCH) ? from_reg : addr_reg;
    assign any_hit = |hitv_reg;

    // entry selection from the registered hit vector
    always_comb begin
        sel_cnt  = '0;
        sel_succ = '0;
        hit_idx  = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hitv_reg[i]) begin
                sel_cnt  = sel_cnt | ct[i];
                sel_succ = sel_succ | sc[i];
                hit_idx  = hit_idx | IW'(i);
            end
        end
    end

    // successor list update: swap a known successor to the front, else push
    always_comb begin
        found   = 1'b0;
        found_j = '0;
        for (int j = SUCCESSORS - 1; j >= 0; j--) begin
            if (CW'(j) < sel_cnt && sel_succ[j*ADDR_WIDTH +: ADDR_WIDTH] == to_reg) begin
                found   = 1'b1;
                found_j = CW'(j);
            end
        end
        upd_succ = sel_succ;
        upd_cnt  = sel_cnt;
        if (found) begin
            for (int j = 0; j < SUCCESSORS; j++) begin
                if (CW'(j) == found_j) begin
                    upd_succ[j*ADDR_WIDTH +: ADDR_WIDTH] = sel_succ[0 +: ADDR_WIDTH];
                    upd_succ[0 +: ADDR_WIDTH] = sel_succ[j*ADDR_WIDTH +: ADDR_WIDTH];
                end
            end
        end else begin
            upd_succ[0 +: ADDR_WIDTH] = to_reg;
            for (int j = 1; j < SUCCESSORS; j++) begin
                upd_succ[j*ADDR_WIDTH +: ADDR_WIDTH] = sel_succ[(j-1)*ADDR_WIDTH +: ADDR_WIDTH];
            end
            if (sel_cnt < CW'(SUCCESSORS)) begin
                upd_cnt = sel_cnt + CW'(1);
            end
        end
    end

    // cell control
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            ctl[i].op     = CELL_HOLD;
            ctl[i].cmp_en = (state_reg == ST_MATCH) || (state_reg == ST_LOOK);
            if (state_reg == ST_UPD) begin
                if (!any_hit) begin
                    ctl[i].op = CELL_SHIFT;
                end else if (i == 0 || IW'(i) == hit_idx) begin
                    ctl[i].op = CELL_LOAD;
                end
            end
        end
    end

    logic [LW-1:0] new_succ;
    assign new_succ = LW'(to_reg);

    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        logic                  shv, ldv;
        logic [ADDR_WIDTH-1:0] sht, ldt;
        logic [CW-1:0]         shc, ldc;
        logic [LW-1:0]         shs, lds;
        if (i == 0) begin : g_front
            assign shv = 1'b1;
            assign sht = from_reg;
            assign shc = CW'(1);
            assign shs = new_succ;
            assign ldv = 1'b1;
            assign ldt = from_reg;
            assign ldc = upd_cnt;
            assign lds = upd_succ;
        end else begin : g_rest
            assign shv = vld[i-1];
            assign sht = tg[i-1];
            assign shc = ct[i-1];
            assign shs = sc[i-1];
            assign ldv = vld[0];
            assign ldt = tg[0];
            assign ldc = ct[0];
            assign lds = sc[0];
        end
        mmp_cell #(
            .SUCCESSORS (SUCCESSORS),
            .ADDR_WIDTH (ADDR_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl[i]),
            .cmp_addr (cmp_addr),
            .sh_valid (shv),
            .sh_tag   (sht),
            .sh_cnt   (shc),
            .sh_succ  (shs),
            .ld_valid (ldv),
            .ld_tag   (ldt),
            .ld_cnt   (ldc),
            .ld_succ  (lds),
            .valid    (vld[i]),
            .tag      (tg[i]),
            .cnt      (ct[i]),
            .succ     (sc[i]),
            .match    (mt[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    state_next = (seed || s_tuser) ? ST_MATCH : ST_LOOK;
                end
            end
            ST_MATCH: state_next = ST_UPD;
            ST_UPD:   state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_SEL;
            ST_SEL:   state_next = (any_hit && sel_cnt != '0) ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (m_acc && rem_reg == CW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bsize_reg <= LINE_BYTES_RESET;
            prev_reg  <= '0;
            hitv_reg  <= '0;
            rem_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                bsize_reg <= cfg_wdata;
            end
            if (s_acc && (seed || s_tuser)) begin
                prev_reg <= in_addr;
            end
            if (state_reg == ST_MATCH || state_reg == ST_LOOK) begin
                hitv_reg <= mt;
            end
            if (state_reg == ST_SEL) begin
                rem_reg <= sel_cnt;
            end else if (m_acc) begin
                rem_reg <= rem_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            addr_reg <= in_addr;
            if (seed) begin
                from_reg <= in_addr;
                to_reg   <= in_addr + ADDR_WIDTH'(bsize_reg);
            end else begin
                from_reg <= prev_reg;
                to_reg   <= in_addr;
            end
        end
        if (state_reg == ST_SEL) begin
            ob_reg <= sel_succ;
        end else if (m_acc) begin
            ob_reg <= ob_reg >> ADDR_WIDTH;
        end
    end

    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tdata  = DW'(ob_reg[ADDR_WIDTH-1:0]);
    assign m_tlast  = (rem_reg == CW'(1));

    logic [TABLE_ENTRIES:0] vld_p1;
    assign vld_p1 = {1'b0, vld} + (TABLE_ENTRIES + 1)'(1);

`ifndef NO_ASSERTIONS
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(vld_p1)) else $error("valid entries not a prefix");
    a_hit1: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hitv_reg)) else $error("duplicate tags in table");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accepting while emitting");
    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rem_reg != '0)) else $error("emit with empty count");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for markov_miss_prefetcher: random accesses with
// stalls, a table predictor, and in-order compare of prefetch addresses and last flags.
// Depends on mmp_pkg and the markov_miss_prefetcher RTL.
module testbench import mmp_pkg::*; ();

    localparam int NE = 16;
    localparam int NS = 5;
    localparam int AW = 48;
    localparam int DW = 48;

    typedef struct {
        logic [AW-1:0] addr;
        logic          miss;
    } access_t;

    typedef struct {
        logic [AW-1:0] addr;
        logic          last;
    } pref_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [LINE_BYTES_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [DW-1:0] m_tdata;
    logic m_tlast;

    markov_miss_prefetcher u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    // predictor state
    logic          tbl_valid [NE];
    logic [AW-1:0] tbl_tag [NE];
    int            tbl_cnt [NE];
    logic [AW-1:0] tbl_succ [NE][NS];
    logic [AW-1:0] prev_miss;
    logic [12:0]   blk_size;

    access_t pending[$];
    pref_t   expected_prefetch[$];
    int errors = 0;
    int sent = 0;
    int accepted = 0;
    int hold_off = 0;
    longint cycles = 0;

    function automatic int used_count();
        int n = 0;
        while (n < NE && tbl_valid[n]) n++;
        return n;
    endfunction

    function automatic int lookup(logic [AW-1:0] tag);
        int u = used_count();
        for (int i = 0; i < u; i++)
            if (tbl_tag[i] == tag) return i;
        return -1;
    endfunction

    task automatic swap_slots(int a, int b);
        logic v;
        logic [AW-1:0] t;
        int c;
        logic [AW-1:0] s;
        v = tbl_valid[a]; tbl_valid[a] = tbl_valid[b]; tbl_valid[b] = v;
        t = tbl_tag[a]; tbl_tag[a] = tbl_tag[b]; tbl_tag[b] = t;
        c = tbl_cnt[a]; tbl_cnt[a] = tbl_cnt[b]; tbl_cnt[b] = c;
        for (int k = 0; k < NS; k++) begin
            s = tbl_succ[a][k]; tbl_succ[a][k] = tbl_succ[b][k]; tbl_succ[b][k] = s;
        end
    endtask

    task automatic learn_transition(logic [AW-1:0] from, logic [AW-1:0] to);
        int u, i, j, n;
        logic [AW-1:0] t;
        u = used_count();
        i = lookup(from);
        if (i >= 0) begin
            n = tbl_cnt[i];
            for (j = 0; j < n; j++)
                if (tbl_succ[i][j] == to) break;
            if (j < n) begin
                t = tbl_succ[i][0];
                tbl_succ[i][0] = tbl_succ[i][j];
                tbl_succ[i][j] = t;
            end else begin
                if (n < NS) n++;
                for (j = n - 1; j > 0; j--) tbl_succ[i][j] = tbl_succ[i][j-1];
                tbl_succ[i][0] = to;
                tbl_cnt[i] = n;
            end
            if (i != 0) swap_slots(0, i);
        end else begin
            if (u < NE) u++;
            for (i = u - 1; i > 0; i--) begin
                tbl_valid[i] = tbl_valid[i-1];
                tbl_tag[i] = tbl_tag[i-1];
                tbl_cnt[i] = tbl_cnt[i-1];
                for (int k = 0; k < NS; k++) tbl_succ[i][k] = tbl_succ[i-1][k];
            end
            tbl_valid[0] = 1;
            tbl_tag[0] = from;
            tbl_cnt[0] = 1;
            tbl_succ[0][0] = to;
        end
    endtask

    task automatic predict_prefetch(access_t a);
        int h;
        pref_t p;
        if (!tbl_valid[0]) begin
            learn_transition(a.addr, a.addr + AW'(blk_size));
            prev_miss = a.addr;
        end else if (a.miss) begin
            learn_transition(prev_miss, a.addr);
            prev_miss = a.addr;
        end
        h = lookup(a.addr);
        if (h >= 0)
            for (int k = 0; k < tbl_cnt[h]; k++) begin
                p.addr = tbl_succ[h][k];
                p.last = (k + 1 == tbl_cnt[h]);
                expected_prefetch.push_back(p);
            end
    endtask

    // driver
    int s_gap = 0;
    always @(posedge aclk) begin
        cycles++;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_prefetch(access_t'{s_tdata[AW-1:0], s_tuser});
                accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (s_tvalid && s_tready) void'(pending.pop_front());
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 0;
                end else if (pending.size() > 0) begin
                    s_tvalid <= 1;
                    s_tdata <= pending[0].addr;
                    s_tuser <= pending[0].miss;
                    s_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                          : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
        if (cycles > 400000) begin
            $display("%0t timeout", $time);
            $display("** markov_miss_prefetcher: FAILED **");
            $finish;
        end
    end

    // monitor and result-side stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_prefetch.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result addr=%h last=%b", $time,
                             m_tdata, m_tlast);
                end else begin
                    pref_t e;
                    e = expected_prefetch.pop_front();
                    if (m_tdata[AW-1:0] !== e.addr) begin
                        errors++;
                        $display("%0t addr exp=%h got=%h", $time, e.addr, m_tdata);
                    end
                    if (m_tlast !== e.last) begin
                        errors++;
                        $display("%0t last exp=%b got=%b", $time, e.last, m_tlast);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 0;
            end else if ($urandom_range(0, 2) == 0) begin
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic wait_drained();
        while (pending.size() > 0 || s_tvalid || expected_prefetch.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_line_bytes(logic [12:0] v);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        blk_size = v;
    endtask

    function automatic logic [AW-1:0] rand_addr();
        return AW'({$urandom, $urandom});
    endfunction

    task automatic add_access(logic [AW-1:0] a, logic m);
        pending.push_back(access_t'{a, m});
        sent++;
    endtask

    logic [AW-1:0] pool [24];

    initial begin
        for (int i = 0; i < NE; i++) begin
            tbl_valid[i] = 0; tbl_tag[i] = 0; tbl_cnt[i] = 0;
            for (int k = 0; k < NS; k++) tbl_succ[i][k] = 0;
        end
        prev_miss = 0;
        blk_size = LINE_BYTES_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // seed with overflow wrap, then build lists past the successor cap
        add_access({AW{1'b1}} - 10, 1'b0);
        add_access({AW{1'b1}} - 10, 1'b1);
        add_access('0, 1'b1);
        add_access({AW{1'b1}}, 1'b1);
        for (int i = 0; i < 7; i++) begin
            add_access(48'h1000, 1'b1);
            add_access(48'h2000 + i, 1'b1);
        end
        add_access(48'h1000, 1'b0);
        add_access(48'h2003, 1'b0);
        add_access(48'h5555, 1'b0);
        wait_drained();

        // back-pressure: receiver stalls long while accesses queue up
        hold_off = 200;
        for (int i = 0; i < 20; i++)
            add_access(48'h1000 + 48'h1000 * (i % 2), (i % 2) == 1);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            logic [12:0] bs;
            bs = (ph == 0) ? 13'd1 : (ph == 1) ? 13'd4096 : (ph == 2) ? 13'd0 : 13'h1FFF;
            write_line_bytes(bs);
            for (int i = 0; i < 24; i++)
                pool[i] = ($urandom_range(0, 3) == 0) ? rand_addr()
                        : AW'($urandom_range(0, 31)) << 6;
            for (int i = 0; i < 55; i++) begin
                if ($urandom_range(0, 9) == 0)
                    add_access(rand_addr(), $urandom_range(0, 1) == 1);
                else
                    add_access(pool[$urandom_range(0, 23)], $urandom_range(0, 3) != 0);
            end
            wait_drained();
        end

        if (errors == 0)
            $display("** markov_miss_prefetcher: PASSED **");
        else
            $display("** markov_miss_prefetcher: FAILED **");
        $finish;
    end
endmodule
